FILE: rtl/ilir_pkg.sv
// indexed list insert/remove: shared codes, payload and control types
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package ilir_pkg;

   localparam int KIND_W   = 2;
   localparam int POS_W    = 8;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   // operation codes
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0]        kind;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] new_value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic [COUNT_W-1:0]       entry_count;
      logic signed [DATA_W-1:0] read_data;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;    // capture the request
      logic start;   // seed the shift pointer, read at position
      logic step;    // move one entry
      logic commit;  // final write, count update, result capture
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic shift_op;  // accepted insert or remove
      logic more;      // entries left to move
   } dp_status_type;

endpackage

FILE: rtl/indexed_list_insert_remove.sv
// indexed list insert/remove: top level joining controller and datapath
// depends on ilir_pkg, ilir_ctrl, ilir_dp
//
//  channel   handshake              payload             direction
//  request   req_valid / req_ready  req_data  req_type  in
//  response  rsp_valid / rsp_ready  rsp_data  rsp_type  out
//
// read, rejected request or unused kind: goes from the start step straight to finish
// insert or remove moving n entries shifts them one by one; the entry memory has
// one write and one read port and moves one entry per cycle; n is at most DEPTH - 1
// reset clears the count, state and flags; entries are not cleared and there is no sweep
// one request in flight; a finished result waits in the output register and
// the next request is taken while it waits, the block holds only at the end
// of that next request if the first is still not taken
`timescale 1ns / 1ps

module indexed_list_insert_remove
   import ilir_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   ilir_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   ilir_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .dp_status (dp_status),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: rtl/ilir_ctrl.sv
// indexed list insert/remove: sequencing state machine and result valid flag
// depends on ilir_pkg
`timescale 1ns / 1ps

module ilir_ctrl
   import ilir_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type dp_status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_START,
      S_SHIFT,
      S_FINISH
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_START;
            end
         end
         S_START: begin
            cmd.start = 1'b1;
            state_in  = dp_status.shift_op ? S_SHIFT : S_FINISH;
         end
         S_SHIFT: begin
            // the last pending write lands on the exit edge
            cmd.step = 1'b1;
            if (!dp_status.more) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (slot_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   // a new result never overwrites one that is still waiting
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before it was taken");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.commit))
      else $error("result valid raised without a commit");

   // an accepted request always goes through the start step next
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_START))
      else $error("accepted request not started");
`endif

endmodule

FILE: rtl/ilir_dp.sv
// indexed list insert/remove: entry memory, count, shift pointers, result register
// depends on ilir_pkg; driven by ilir_ctrl commands
`timescale 1ns / 1ps

module ilir_dp
   import ilir_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  ctrl_cmd_type  cmd,
   input  req_type       req_data,
   output dp_status_type dp_status,
   output rsp_type       rsp_data
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   logic [DATA_W-1:0] entry_mem [DEPTH];

   req_type           req_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [IDX_W-1:0]  dest_ff;
   logic [IDX_W-1:0]  wdst_ff;
   logic              pend_ff;
   logic [DATA_W-1:0] rd_data_ff;
   rsp_type           rsp_ff;

   logic              is_ins, is_rem, is_rd;
   logic [CMP_W-1:0]  pos_cmp, cnt_cmp;
   logic              in_range, full, ins_ok, rem_ok, rd_ok;
   logic [IDX_W-1:0]  pos_idx, at_idx, src_idx, seed_idx;
   logic              more;
   logic [CNT_W-1:0]  count_next;
   logic [STATUS_W-1:0] status;
   logic              mem_we, mem_re;
   logic [IDX_W-1:0]  mem_waddr, mem_raddr;
   logic [DATA_W-1:0] mem_wdata;

   // decode of the held request against the current count
   assign is_ins   = (req_ff.kind == KIND_INSERT);
   assign is_rem   = (req_ff.kind == KIND_REMOVE);
   assign is_rd    = (req_ff.kind == KIND_READ);
   assign pos_cmp  = CMP_W'(req_ff.position);
   assign cnt_cmp  = CMP_W'(count_ff);
   assign in_range = (pos_cmp < cnt_cmp);
   assign full     = (cnt_cmp >= CMP_W'(DEPTH));
   assign ins_ok   = is_ins && !full;
   assign rem_ok   = is_rem && in_range;
   assign rd_ok    = is_rd && in_range;
   assign pos_idx  = IDX_W'(req_ff.position);
   // insert beyond the count appends
   assign at_idx   = in_range ? pos_idx : IDX_W'(count_ff);
   assign seed_idx = is_ins ? IDX_W'(count_ff) : pos_idx;
   assign src_idx  = is_ins ? (dest_ff - IDX_W'(1)) : (dest_ff + IDX_W'(1));
   assign more     = is_ins ? (dest_ff != at_idx)
                            : ((CNT_W'(dest_ff) + CNT_W'(1)) != count_ff);

   always_comb begin
      status = STATUS_OK;
      if (is_ins && full) begin
         status = STATUS_FULL;
      end else if ((is_rem || is_rd) && !in_range) begin
         status = STATUS_RANGE;
      end
   end

   always_comb begin
      count_next = count_ff;
      if (ins_ok) begin
         count_next = count_ff + CNT_W'(1);
      end else if (rem_ok) begin
         count_next = count_ff - CNT_W'(1);
      end
   end

   assign dp_status.shift_op = ins_ok || rem_ok;
   assign dp_status.more     = more;

   // single write port, single registered read port; one entry moves per cycle
   assign mem_re    = cmd.start || (cmd.step && more);
   assign mem_raddr = cmd.start ? pos_idx : src_idx;
   assign mem_we    = (cmd.step && pend_ff) || (cmd.commit && ins_ok);
   assign mem_waddr = cmd.commit ? at_idx : wdst_ff;
   assign mem_wdata = cmd.commit ? DATA_W'(req_ff.new_value) : rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= entry_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.start) begin
         dest_ff <= seed_idx;
      end else if (cmd.step && more) begin
         dest_ff <= src_idx;
         wdst_ff <= dest_ff;
      end
      if (cmd.commit) begin
         rsp_ff.status      <= status;
         rsp_ff.entry_count <= COUNT_W'(count_next);
         rsp_ff.read_data   <= rd_ok ? rd_data_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         if (cmd.commit) begin
            count_ff <= count_next;
         end
         if (cmd.start) begin
            pend_ff <= 1'b0;
         end else if (cmd.step) begin
            pend_ff <= more;
         end
      end
   end

   assign rsp_data = rsp_ff;

`ifndef ASSERT_OFF
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   // read-ahead must never hit the entry being written back
   assert property (@(posedge clock) disable iff (reset)
      (cmd.step && pend_ff && more) |-> (src_idx != wdst_ff))
      else $error("shift read collides with pending write");

   assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (CNT_W'(wdst_ff) <= count_ff))
      else $error("shift write outside the list");
`endif

endmodule

FILE: tb/tb_indexed_list_insert_remove.sv
// testbench for indexed_list_insert_remove: predicts every list edit and read
// and checks each response; depends on ilir_pkg and the indexed_list_insert_remove rtl
`timescale 1ns / 1ps

module tb_indexed_list_insert_remove;
   import ilir_pkg::*;

   localparam int LIST_DEPTH     = 64;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 100;

   // kind value with no operation behind it
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   indexed_list_insert_remove #(.DEPTH(LIST_DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   // predicted list contents and the responses still owed by the block
   logic signed [DATA_W-1:0] list_mem [LIST_DEPTH];
   int                       list_count = 0;
   rsp_type                  owed_rsp [$];

   int  fail_count = 0;
   int  idle_cycles = 0;
   bit  no_idle = 1'b0;
   int  n_insert = 0, n_remove = 0, n_read = 0, n_unused = 0;
   int  n_full = 0, n_range = 0, peak_count = 0, n_checked = 0;

   function automatic rsp_type apply_list_edit(req_type r);
      rsp_type res;
      int      at;
      res = '0;
      res.status = STATUS_OK;
      case (r.kind)
         KIND_INSERT: begin
            n_insert++;
            if (list_count >= LIST_DEPTH) begin
               res.status = STATUS_FULL;
               n_full++;
            end else begin
               at = (int'(r.position) >= list_count) ? list_count : int'(r.position);
               for (int i = list_count; i > at; i--) list_mem[i] = list_mem[i-1];
               list_mem[at] = r.new_value;
               list_count++;
            end
         end
         KIND_REMOVE: begin
            n_remove++;
            if (int'(r.position) >= list_count) begin
               res.status = STATUS_RANGE;
               n_range++;
            end else begin
               for (int i = int'(r.position); i + 1 < list_count; i++)
                  list_mem[i] = list_mem[i+1];
               list_count--;
            end
         end
         KIND_READ: begin
            n_read++;
            if (int'(r.position) >= list_count) begin
               res.status = STATUS_RANGE;
               n_range++;
            end else begin
               res.read_data = list_mem[r.position];
            end
         end
         default: n_unused++;
      endcase
      if (list_count > peak_count) peak_count = list_count;
      res.entry_count = list_count[COUNT_W-1:0];
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
      fail_count++;
      $display("[%0t] mismatch: %s got %0h expected %0h", $realtime, what, got, want);
   endtask

   // sends one request after a random gap (none while no_idle is set), returns at the edge it is taken
   task automatic send_request(req_type r);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      forever begin
         @(posedge clock);
         if (req_ready) break;
      end
      owed_rsp.push_back(apply_list_edit(r));
   endtask

   task automatic send_op(logic [KIND_W-1:0] kind, int pos, logic [DATA_W-1:0] val);
      req_type r;
      r.kind      = kind;
      r.position  = pos[POS_W-1:0];
      r.new_value = val;
      send_request(r);
   endtask

   function automatic int pick_position();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 7) return $urandom_range(0, list_count);
      if (sel < 9) return $urandom_range(0, 255);
      return ($urandom_range(0, 1) != 0) ? 255 : list_count;
   endfunction

   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'hffff_ffff;
         3:       return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   // insert_pct and remove_pct set the mix; of the rest, rolls of 97 and up are the unused kind, others reads
   task automatic send_random(int insert_pct, int remove_pct);
      int                  roll;
      logic [KIND_W-1:0]   kind;
      roll = $urandom_range(0, 99);
      if (roll < insert_pct) kind = KIND_INSERT;
      else if (roll < insert_pct + remove_pct) kind = KIND_REMOVE;
      else if (roll < 97) kind = KIND_READ;
      else kind = KIND_UNUSED;
      send_op(kind, pick_position(), pick_value());
   endtask

   task automatic shuffle_idling(int n);
      if (n % 32 == 0) no_idle = ($urandom_range(0, 3) == 0);
   endtask

   task automatic test_directed();
      send_op(KIND_READ, 0, 32'h1234_5678);
      send_op(KIND_REMOVE, 0, '0);
      send_op(KIND_READ, 255, '0);
      send_op(KIND_UNUSED, 0, 32'hdead_beef);
      send_op(KIND_INSERT, 255, 32'h7fff_ffff);
      send_op(KIND_INSERT, 0, 32'h8000_0000);
      send_op(KIND_INSERT, 1, 32'h0000_0000);
      send_op(KIND_INSERT, 3, 32'hffff_ffff);
      send_op(KIND_INSERT, 2, 32'h5555_5555);
      for (int i = 0; i < 6; i++) send_op(KIND_READ, i, '0);
      send_op(KIND_REMOVE, 2, '0);
      send_op(KIND_REMOVE, 3, '0);
      send_op(KIND_REMOVE, 0, '0);
      send_op(KIND_READ, 0, '0);
      send_op(KIND_READ, 1, '0);
      send_op(KIND_UNUSED, 255, 32'hffff_ffff);
      send_op(KIND_REMOVE, 200, '0);
      send_op(KIND_REMOVE, 1, '0);
      send_op(KIND_REMOVE, 0, '0);
      send_op(KIND_READ, 0, '0);
   endtask

   // grow until the list is full, then keep pushing into the full list
   task automatic test_fill_to_full();
      int n, extra;
      n = 0;
      extra = 0;
      while (extra < 20 && n < 400) begin
         shuffle_idling(n);
         send_random(80, 10);
         if (list_count == LIST_DEPTH) extra++;
         n++;
      end
   endtask

   task automatic test_drain_to_empty();
      int n, extra;
      n = 0;
      extra = 0;
      while (extra < 10 && n < 400) begin
         shuffle_idling(n);
         send_random(5, 90);
         if (list_count == 0) extra++;
         n++;
      end
   endtask

   task automatic test_mixed_edits();
      for (int n = 0; n < 50; n++) begin
         shuffle_idling(n);
         send_random(40, 35);
      end
   endtask

   task automatic wait_for_drain();
      while (owed_rsp.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // response side: random stall per response (none while no_idle is set), compare against the oldest owed
   initial begin
      int      stall;
      rsp_type want;
      while (reset) @(posedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         n_checked++;
         if (owed_rsp.size() == 0) begin
            report_mismatch("response with no request owed", rsp_data.read_data, '0);
         end else begin
            want = owed_rsp.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch("status", DATA_W'(rsp_data.status), DATA_W'(want.status));
            if (rsp_data.entry_count !== want.entry_count)
               report_mismatch("entry_count", DATA_W'(rsp_data.entry_count),
                               DATA_W'(want.entry_count));
            if (rsp_data.read_data !== want.read_data)
               report_mismatch("read_data", rsp_data.read_data, want.read_data);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no request or response moved for %0d cycles", idle_cycles);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_fill_to_full();
      test_drain_to_empty();
      test_mixed_edits();
      test_fill_to_full();
      req_valid <= 1'b0;
      wait_for_drain();
      if (owed_rsp.size() != 0)
         report_mismatch("responses never returned", DATA_W'(owed_rsp.size()), '0);
      $display("covered %0d inserts, %0d removes, %0d reads, %0d unused kinds; %0d responses",
               n_insert, n_remove, n_read, n_unused, n_checked);
      $display("full rejects %0d, range rejects %0d, deepest list %0d entries",
               n_full, n_range, peak_count);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
